>>> rtl/pgm_pkg.sv
// ----------------------------------------------------------------------------
// pgm_pkg
// shared types, constants and helpers for the binary gray map parser
// ----------------------------------------------------------------------------
`default_nettype none
package pgm_pkg;
    localparam int DIM_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [7:0] C_CHAR_P    = 8'h50;
    localparam logic [7:0] C_CHAR_5    = 8'h35;
    localparam logic [7:0] C_CHAR_HASH = 8'h23;
    localparam logic [7:0] C_CHAR_LF   = 8'h0A;
    localparam logic [7:0] C_CHAR_PLUS = 8'h2B;
    localparam logic [7:0] C_CHAR_X_LO = 8'h78;
    localparam logic [7:0] C_CHAR_X_UP = 8'h58;
    localparam logic [8:0] C_GRAY_LIMIT = 9'd255;

    localparam logic [2:0] ST_PIXEL    = 3'd0;
    localparam logic [2:0] ST_BAD_MAG  = 3'd1;
    localparam logic [2:0] ST_HDR_ERR  = 3'd2;
    localparam logic [2:0] ST_MAX_ERR  = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    typedef enum logic [3:0] {
        PH_MAGIC0, PH_MAGIC1, PH_PRE, PH_COMMENT, PH_NSTART, PH_NSIGN,
        PH_NDIGITS, PH_NHEXPFX, PH_DIVIDE, PH_PIXELS, PH_DIV_PIX, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        RX_UNDEC, RX_DEC, RX_OCT, RX_HEX
    } t_radix;

    // datapath command from the controller
    typedef enum logic [2:0] {
        DC_NONE, DC_CLEAR, DC_BEGIN, DC_ACCUM, DC_FINISH, DC_HEXFIRST, DC_DIV_START,
        DC_PIXEL
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [7:0] byte_value;
        t_radix     radix;
    } t_dp_cmd;

    typedef struct packed {
        logic       div_busy;
        logic       final_px;
        logic       fin_err_hdr;
        logic       fin_err_max;
        logic       fin_is_max;
    } t_dp_status;

    function automatic logic is_ws(input logic [7:0] b);
        is_ws = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic [4:0] digit_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) digit_of = {1'b0, b[3:0]};
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            digit_of = 5'd9 + {1'b0, b[3:0]};
        else digit_of = 5'd16;
    endfunction
endpackage
`default_nettype wire

>>> rtl/pgm_if.sv
// ----------------------------------------------------------------------------
// pgm_in_if / pgm_out_if
// valid/ready channels for file bytes and result items
// ----------------------------------------------------------------------------
`default_nettype none
interface pgm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;
    modport source (output valid, byte_value, last_byte, input ready);
    modport sink (input valid, byte_value, last_byte, output ready);
endinterface

interface pgm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_fraction;
    logic [15:0] pixel_row;
    logic [15:0] pixel_col;
    logic [2:0]  status;
    logic        image_done;
    modport source (output valid, pixel_fraction, pixel_row, pixel_col, status, image_done,
                    input ready);
    modport sink (input valid, pixel_fraction, pixel_row, pixel_col, status, image_done,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/pgm_datapath.sv
// ----------------------------------------------------------------------------
// pgm_datapath
// number accumulator, header registers, pixel counters and restoring divider
// ----------------------------------------------------------------------------
`default_nettype none
module pgm_datapath import pgm_pkg::*; #(
    parameter int DIM_BITS  = DIM_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_status       o_status,
    output logic [15:0]      o_frac,
    output logic [15:0]      o_row,
    output logic [15:0]      o_col
);
    localparam int NB = FRAC_BITS + 8;
    localparam int CW = $clog2(NB + 1);
    localparam logic [DIM_BITS:0] CAP = {1'b1, {DIM_BITS{1'b0}}};

    logic [DIM_BITS:0]   r_accum, n_accum;
    logic [DIM_BITS-1:0] r_width, r_height, r_col, r_row;
    logic [7:0]          r_gmax;
    logic [NB-1:0]       r_quot;
    logic [8:0]          r_rem;
    logic [NB-1:0]       r_num;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;

    logic [4:0]          w_d;
    logic [DIM_BITS+5:0] w_prod;
    logic [DIM_BITS+5:0] w_sum;
    logic [8:0]          w_div;
    logic [9:0]          w_trial;
    logic [NB-1:0]       w_num;
    logic                w_final;

    assign w_d   = digit_of(i_cmd.byte_value);
    assign w_div = {1'b0, r_gmax} + 9'd1;
    assign w_num = {i_cmd.byte_value, {FRAC_BITS{1'b0}}};

    always_comb begin
        case (i_cmd.radix)
            RX_HEX:  w_prod = {1'b0, r_accum, 4'b0};
            RX_OCT:  w_prod = {2'b0, r_accum, 3'b0};
            default: w_prod = {2'b0, r_accum, 3'b0} + {4'b0, r_accum, 1'b0};
        endcase
        w_sum = w_prod + {{(DIM_BITS+1){1'b0}}, w_d};
        n_accum = (w_sum > {5'b0, CAP}) ? CAP : w_sum[DIM_BITS:0];
    end

    assign w_final = (r_col + 1'b1 == r_width) && (r_row + 1'b1 == r_height);
    assign w_trial = {r_rem, r_num[NB-1]} - {1'b0, w_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0; r_width <= '0; r_height <= '0; r_gmax <= '0;
            r_col <= '0; r_row <= '0; r_busy <= 1'b0;
        end else begin
            case (i_cmd.op)
                DC_CLEAR: begin
                    r_accum <= '0; r_width <= '0; r_height <= '0; r_gmax <= '0;
                    r_col <= '0; r_row <= '0;
                end
                DC_BEGIN:    r_accum <= {{(DIM_BITS-4){1'b0}}, w_d};
                DC_HEXFIRST: r_accum <= {{(DIM_BITS-4){1'b0}}, w_d};
                DC_ACCUM:    r_accum <= n_accum;
                DC_FINISH: begin
                    r_accum <= '0;
                    if (r_width == '0) r_width <= r_accum[DIM_BITS-1:0];
                    else if (r_height == '0) r_height <= r_accum[DIM_BITS-1:0];
                    else r_gmax <= r_accum[7:0];
                end
                DC_DIV_START: begin
                    r_num <= w_num; r_busy <= 1'b1;
                    r_cnt <= '0; r_rem <= '0; r_quot <= '0;
                end
                DC_PIXEL: begin
                    if (!w_final) begin
                        if (r_col + 1'b1 >= r_width) begin
                            r_col <= '0; r_row <= r_row + 1'b1;
                        end else r_col <= r_col + 1'b1;
                    end
                end
                default: ;
            endcase
            if (r_busy) begin
                if (!w_trial[9]) begin
                    r_rem <= w_trial[8:0]; r_quot <= {r_quot[NB-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[7:0], r_num[NB-1]};
                    r_quot <= {r_quot[NB-2:0], 1'b0};
                end
                r_num <= {r_num[NB-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NB - 1)) r_busy <= 1'b0;
            end
        end
    end

    assign o_status.div_busy    = r_busy;
    assign o_status.final_px    = w_final;
    assign o_status.fin_is_max  = (r_width != '0) && (r_height != '0);
    assign o_status.fin_err_hdr = (r_accum == '0) ||
                                  (!o_status.fin_is_max && r_accum[DIM_BITS]);
    assign o_status.fin_err_max = o_status.fin_is_max && (r_accum > (DIM_BITS+1)'(C_GRAY_LIMIT));
    assign o_frac = (r_quot[NB-1:FRAC_BITS] != '0) ? 16'hFFFF : 16'(r_quot[FRAC_BITS-1:0]);
    assign o_row  = 16'(r_row);
    assign o_col  = 16'(r_col);
endmodule
`default_nettype wire

>>> rtl/pgm_ctrl.sv
// ----------------------------------------------------------------------------
// pgm_ctrl
// phase state machine: header parsing, pixel sequencing, result handshake
// ----------------------------------------------------------------------------
`default_nettype none
module pgm_ctrl import pgm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pgm_in_if.sink     in_ch,
    input  wire logic  i_out_ready,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd,
    output logic       o_out_valid,
    output logic [2:0] o_out_status,
    output logic       o_out_done,
    output logic       o_out_err
);
    t_phase r_ph, n_ph;
    t_radix r_rx, n_rx;
    logic   r_ov, n_ov;
    logic [2:0] r_ost, n_ost;
    logic   r_odone, n_odone, r_oerr, n_oerr;
    logic   r_last, n_last, r_fin, n_fin;
    logic   w_acc;
    logic [4:0] w_d;
    logic [7:0] b;
    logic [2:0] w_err;
    logic   w_emit;

    assign b = in_ch.byte_value;
    assign w_d = digit_of(b);
    assign in_ch.ready = (!r_ov || i_out_ready) && r_ph != PH_DIV_PIX;
    assign w_acc = in_ch.valid && in_ch.ready;

    // next state
    always_comb begin
        n_ph = r_ph; n_rx = r_rx; w_err = ST_PIXEL; w_emit = 1'b0;
        n_last = r_last; n_fin = r_fin;
        n_ov = r_ov && !i_out_ready;
        n_ost = r_ost; n_odone = r_odone; n_oerr = r_oerr;
        if (r_ph == PH_DIV_PIX) begin
            if (!i_st.div_busy) begin
                n_ov = 1'b1; n_ost = ST_PIXEL; n_odone = r_fin; n_oerr = 1'b0;
                n_ph = r_last ? PH_MAGIC0 : (r_fin ? PH_DONE : PH_PIXELS);
                n_rx = r_last ? RX_UNDEC : r_rx;
            end
        end else if (w_acc) begin
            case (r_ph)
                PH_MAGIC0: if (b == C_CHAR_P) n_ph = PH_MAGIC1; else w_err = ST_BAD_MAG;
                PH_MAGIC1: if (b == C_CHAR_5) n_ph = PH_PRE; else w_err = ST_BAD_MAG;
                PH_PRE, PH_NSTART: begin
                    if (r_ph == PH_PRE && is_ws(b)) ;
                    else if (r_ph == PH_PRE && b == C_CHAR_HASH) n_ph = PH_COMMENT;
                    else if (is_ws(b)) n_ph = PH_NSTART;
                    else if (b == C_CHAR_PLUS) n_ph = PH_NSIGN;
                    else if (w_d < 5'd10) begin
                        n_ph = PH_NDIGITS; n_rx = (w_d == 5'd0) ? RX_UNDEC : RX_DEC;
                    end else w_err = ST_HDR_ERR;
                end
                PH_COMMENT: if (b == C_CHAR_LF) n_ph = PH_PRE;
                PH_NSIGN: if (w_d < 5'd10) begin
                    n_ph = PH_NDIGITS; n_rx = (w_d == 5'd0) ? RX_UNDEC : RX_DEC;
                end else w_err = ST_HDR_ERR;
                PH_NDIGITS: begin
                    if (r_rx == RX_UNDEC && (b == C_CHAR_X_LO || b == C_CHAR_X_UP))
                        n_ph = PH_NHEXPFX;
                    else if ((r_rx == RX_UNDEC && w_d < 5'd8) || (r_rx == RX_OCT && w_d < 5'd8)
                             || (r_rx == RX_DEC && w_d < 5'd10) || (r_rx == RX_HEX && w_d < 5'd16))
                        n_rx = (r_rx == RX_UNDEC) ? RX_OCT : r_rx;
                    else begin
                        n_rx = RX_UNDEC;
                        if (i_st.fin_err_hdr) w_err = ST_HDR_ERR;
                        else if (i_st.fin_err_max) w_err = ST_MAX_ERR;
                        else n_ph = i_st.fin_is_max ? PH_PIXELS : PH_NSTART;
                    end
                end
                PH_NHEXPFX: if (w_d < 5'd16) begin
                    n_rx = RX_HEX; n_ph = PH_NDIGITS;
                end else w_err = ST_HDR_ERR;
                PH_PIXELS: begin
                    if (in_ch.last_byte && !i_st.final_px) w_err = ST_TRUNC;
                    else begin
                        w_emit = 1'b1; n_ph = PH_DIV_PIX;
                        n_last = in_ch.last_byte; n_fin = i_st.final_px;
                    end
                end
                default: ;
            endcase
            if (w_err == ST_PIXEL && in_ch.last_byte && !w_emit && r_ph != PH_DONE
                && r_ph != PH_PIXELS) begin
                if (n_ph == PH_MAGIC1) w_err = ST_BAD_MAG;
                else if (n_ph == PH_PIXELS) w_err = ST_TRUNC;
                else w_err = ST_HDR_ERR;
            end
            if (w_err != ST_PIXEL) begin
                n_ov = 1'b1; n_ost = w_err; n_odone = 1'b1; n_oerr = 1'b1;
                n_ph = PH_DONE;
            end
            if (in_ch.last_byte && !w_emit) begin
                n_ph = PH_MAGIC0; n_rx = RX_UNDEC;
            end
        end
    end

    // datapath commands
    always_comb begin
        o_cmd.op = DC_NONE; o_cmd.byte_value = b; o_cmd.radix = r_rx;
        if (r_ph == PH_DIV_PIX) begin
            if (!i_st.div_busy) o_cmd.op = r_last ? DC_CLEAR : DC_PIXEL;
        end else if (w_acc) begin
            if (in_ch.last_byte && !(r_ph == PH_PIXELS && w_err == ST_PIXEL))
                o_cmd.op = DC_CLEAR;
            else case (r_ph)
                PH_PRE, PH_NSTART, PH_NSIGN:
                    if (n_ph == PH_NDIGITS) o_cmd.op = DC_BEGIN;
                PH_NDIGITS: begin
                    if (n_ph == PH_NHEXPFX) o_cmd.op = DC_NONE;
                    else if (n_ph == PH_NDIGITS) o_cmd.op = DC_ACCUM;
                    else o_cmd.op = DC_FINISH;
                    if (r_rx == RX_UNDEC) o_cmd.radix = RX_OCT;
                end
                PH_NHEXPFX: if (n_ph == PH_NDIGITS) o_cmd.op = DC_HEXFIRST;
                PH_PIXELS: o_cmd.op = DC_DIV_START;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_MAGIC0; r_rx <= RX_UNDEC; r_ov <= 1'b0;
            r_last <= 1'b0; r_fin <= 1'b0;
        end else begin
            r_ph <= n_ph; r_rx <= n_rx; r_ov <= n_ov; r_last <= n_last; r_fin <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ost <= n_ost; r_odone <= n_odone; r_oerr <= n_oerr;
    end

    assign o_out_valid  = r_ov;
    assign o_out_status = r_ost;
    assign o_out_done   = r_odone;
    assign o_out_err    = r_oerr;
endmodule
`default_nettype wire

>>> rtl/pgm_binary_stream_parser.sv
// error result valid in the cycle after its byte; pixel result once the divider finishes
// throughput: one header byte per cycle while no result waits; no byte is taken while the
// bit-serial divider by maxval+1 runs (one quotient bit per cycle)
// reset: synchronous active low, parser waits for the first magic byte
// ----------------------------------------------------------------------------
// pgm_binary_stream_parser
// binary gray map stream parser with header checks and pixel scaling
// ----------------------------------------------------------------------------
`default_nettype none
module pgm_binary_stream_parser import pgm_pkg::*; #(
    parameter int DIM_BITS  = DIM_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pgm_in_if.sink    in_ch,
    pgm_out_if.source out_ch
);
    t_dp_cmd    w_cmd;
    t_dp_status w_st;
    logic [15:0] w_frac, w_row, w_col;
    logic [15:0] r_frac, r_row, r_col;
    logic        w_err;

    pgm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .i_out_ready(out_ch.ready),
        .i_st(w_st), .o_cmd(w_cmd), .o_out_valid(out_ch.valid),
        .o_out_status(out_ch.status), .o_out_done(out_ch.image_done), .o_out_err(w_err)
    );

    pgm_datapath #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_st),
        .o_frac(w_frac), .o_row(w_row), .o_col(w_col)
    );

    // pixel fields captured when the divider finishes
    always_ff @(posedge i_clk) begin
        if (w_cmd.op == DC_PIXEL || w_cmd.op == DC_CLEAR) begin
            r_frac <= w_frac; r_row <= w_row; r_col <= w_col;
        end
    end

    assign out_ch.pixel_fraction = w_err ? 16'd0 : r_frac;
    assign out_ch.pixel_row      = w_err ? 16'd0 : r_row;
    assign out_ch.pixel_col      = w_err ? 16'd0 : r_col;

`ifndef SYNTHESIS
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.status != ST_PIXEL |-> out_ch.image_done)
        else $error("error result without done");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("result dropped");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken while result waits");
`endif
endmodule
`default_nettype wire

>>> sim/pgm_binary_stream_parser_tb.sv
// ----------------------------------------------------------------------------
// pgm_binary_stream_parser_tb
// feeds binary gray map files (good, malformed, truncated) through the parser
// and checks every pixel and error result against a cycle-free predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pgm_binary_stream_parser_tb;
    import pgm_pkg::*;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_file_byte;

    typedef struct packed {
        logic [15:0] frac;
        logic [15:0] row;
        logic [15:0] col;
        logic [2:0]  status;
        logic        done;
    } t_pixel_res;

    typedef enum int {
        P_MAG0, P_MAG1, P_PRE, P_CMT, P_NST, P_NSGN, P_NDIG, P_NHEX, P_PIX, P_DONE
    } t_tb_phase;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    pgm_in_if in_ch ();
    pgm_out_if out_ch ();

    pgm_binary_stream_parser DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    t_file_byte byte_q[$];
    t_pixel_res expected_q[$];
    int n_fail = 0;
    int n_pixels = 0;
    int n_errors = 0;
    int n_files = 0;
    int src_idle = 0;
    int snk_idle = 0;
    int hold_cycles = 0;
    bit src_pause = 0;

    // predictor state
    t_tb_phase ph;
    logic [31:0] acc;
    t_radix rdx;
    logic [31:0] wid, hgt, gmax, ccnt, rcnt;

    function automatic bit ws_chk(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic int dig_val(input logic [7:0] b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return 16;
    endfunction

    task automatic parser_clear();
        ph = P_MAG0; acc = 0; rdx = RX_UNDEC;
        wid = 0; hgt = 0; gmax = 0; ccnt = 0; rcnt = 0;
    endtask

    task automatic add_digit(input int base, input int d);
        longint v;
        v = longint'(acc) * base + d;
        acc = (v > 65536) ? 32'd65536 : 32'(v);
    endtask

    function automatic logic [2:0] close_number();
        logic [31:0] v;
        v = acc; acc = 0; rdx = RX_UNDEC;
        if (v == 0) return ST_HDR_ERR;
        if (wid == 0) begin
            if (v > 65535) return ST_HDR_ERR;
            wid = v; ph = P_NST;
        end else if (hgt == 0) begin
            if (v > 65535) return ST_HDR_ERR;
            hgt = v; ph = P_NST;
        end else begin
            if (v > 255) return ST_MAX_ERR;
            gmax = v; ph = P_PIX;
        end
        return ST_PIXEL;
    endfunction

    function automatic logic [2:0] open_number(input logic [7:0] b);
        int d;
        d = dig_val(b);
        if (ws_chk(b)) return ST_PIXEL;
        if (b == C_CHAR_PLUS) begin
            ph = P_NSGN; return ST_PIXEL;
        end
        if (d < 10) begin
            acc = d; rdx = (d == 0) ? RX_UNDEC : RX_DEC; ph = P_NDIG; return ST_PIXEL;
        end
        return ST_HDR_ERR;
    endfunction

    task automatic predict_byte(input t_file_byte fb);
        logic [7:0] b;
        t_tb_phase prev;
        logic [2:0] err;
        int d, base;
        bit emitted, fin;
        longint q;
        t_pixel_res r;
        b = fb.byte_value; prev = ph; err = ST_PIXEL; d = dig_val(b); emitted = 0;
        case (ph)
            P_MAG0: if (b == C_CHAR_P) ph = P_MAG1; else err = ST_BAD_MAG;
            P_MAG1: if (b == C_CHAR_5) ph = P_PRE; else err = ST_BAD_MAG;
            P_PRE: begin
                if (b == C_CHAR_HASH) ph = P_CMT;
                else if (!ws_chk(b)) begin
                    ph = P_NST; err = open_number(b);
                end
            end
            P_CMT: if (b == C_CHAR_LF) ph = P_PRE;
            P_NST: err = open_number(b);
            P_NSGN: begin
                if (d < 10) begin
                    acc = d; rdx = (d == 0) ? RX_UNDEC : RX_DEC; ph = P_NDIG;
                end else err = ST_HDR_ERR;
            end
            P_NDIG: begin
                if (rdx == RX_UNDEC) begin
                    if (b == C_CHAR_X_LO || b == C_CHAR_X_UP) ph = P_NHEX;
                    else if (d < 8) begin
                        rdx = RX_OCT; add_digit(8, d);
                    end else err = close_number();
                end else begin
                    base = (rdx == RX_HEX) ? 16 : (rdx == RX_OCT) ? 8 : 10;
                    if (d < base) add_digit(base, d); else err = close_number();
                end
            end
            P_NHEX: begin
                if (d < 16) begin
                    rdx = RX_HEX; acc = d; ph = P_NDIG;
                end else err = ST_HDR_ERR;
            end
            P_PIX: begin
                fin = (ccnt + 1 == wid) && (rcnt + 1 == hgt);
                if (fb.last_byte && !fin) err = ST_TRUNC;
                else begin
                    q = (longint'(b) << 16) / (gmax + 1);
                    if (q > 65535) q = 65535;
                    r = '{16'(q), 16'(rcnt), 16'(ccnt), ST_PIXEL, fin};
                    expected_q.push_back(r);
                    emitted = 1; n_pixels++;
                    if (fin) ph = P_DONE;
                    else begin
                        ccnt++;
                        if (ccnt >= wid) begin
                            ccnt = 0; rcnt++;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (err == ST_PIXEL && fb.last_byte && !emitted && prev != P_DONE && prev != P_PIX) begin
            if (ph == P_MAG1) err = ST_BAD_MAG;
            else if (ph == P_PIX) err = ST_TRUNC;
            else err = ST_HDR_ERR;
        end
        if (err != ST_PIXEL) begin
            expected_q.push_back('{16'd0, 16'd0, 16'd0, err, 1'b1});
            n_errors++; ph = P_DONE;
        end
        if (fb.last_byte) parser_clear();
    endtask

    // file building
    t_file_byte fbuf[$];

    task automatic put_str(input string s);
        for (int k = 0; k < s.len(); k++) fbuf.push_back('{s[k], 1'b0});
    endtask

    function automatic string num_text(input int v, input int radix);
        string s;
        case (radix)
            0: s = $sformatf("%0d", v);
            1: s = $sformatf("0%0o", v);
            2: s = $sformatf("0x%0h", v);
            default: s = $sformatf("0X%0H", v);
        endcase
        if ($urandom_range(0, 5) == 0) s = {"+", s};
        return s;
    endfunction

    function automatic logic [7:0] sep_byte();
        logic [7:0] seps[6] = '{8'h20, 8'h0A, 8'h09, 8'h0D, 8'h0B, 8'h0C};
        return seps[$urandom_range(0, 5)];
    endfunction

    task automatic build_image(input int w, input int h, input int mx, input int npix);
        put_str("P5");
        if ($urandom_range(0, 2) == 0) begin
            fbuf.push_back('{sep_byte(), 1'b0});
            put_str("# note 0x12 - ");
            fbuf.push_back('{8'($urandom), 1'b0});
            put_str("\n");
        end
        fbuf.push_back('{sep_byte(), 1'b0});
        put_str(num_text(w, $urandom_range(0, 3)));
        fbuf.push_back('{sep_byte(), 1'b0});
        if ($urandom_range(0, 3) == 0) fbuf.push_back('{sep_byte(), 1'b0});
        put_str(num_text(h, $urandom_range(0, 3)));
        fbuf.push_back('{sep_byte(), 1'b0});
        put_str(num_text(mx, $urandom_range(0, 3)));
        fbuf.push_back('{sep_byte(), 1'b0});
        for (int k = 0; k < npix; k++) fbuf.push_back('{8'($urandom), 1'b0});
    endtask

    task automatic commit_file();
        if (fbuf.size() == 0) fbuf.push_back('{8'h50, 1'b0});
        fbuf[$].last_byte = 1'b1;
        foreach (fbuf[k]) byte_q.push_back(fbuf[k]);
        fbuf.delete();
        n_files++;
    endtask

    task automatic random_file();
        int kind, w, h, mx, np;
        kind = $urandom_range(0, 19);
        w = $urandom_range(1, 4); h = $urandom_range(1, 3);
        mx = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 255);
        np = w * h;
        if (kind < 12) begin
            build_image(w, h, mx, np);
            if ($urandom_range(0, 2) == 0) fbuf.push_back('{8'($urandom), 1'b0});
        end else if (kind < 15) begin
            build_image(w, h, mx, $urandom_range(0, np - 1));
        end else if (kind < 18) begin
            build_image(w, h, mx, np);
            np = $urandom_range(1, fbuf.size() - 1);
            fbuf[np].byte_value = 8'($urandom);
        end else begin
            for (int k = $urandom_range(1, 8); k > 0; k--)
                fbuf.push_back('{8'($urandom), 1'b0});
        end
        commit_file();
    endtask

    task automatic directed_file(input string s);
        put_str(s);
        commit_file();
    endtask

    // clock and reset
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // driver
    initial begin
        in_ch.valid = 1'b0;
        in_ch.byte_value = 8'h00;
        in_ch.last_byte = 1'b0;
        out_ch.ready = 1'b0;
    end

    bit fed = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predict_byte('{in_ch.byte_value, in_ch.last_byte});
            fed = 1;
        end else fed = 0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) in_ch.valid <= 1'b0;
        else if (!in_ch.valid || fed) begin
            if (byte_q.size() > 0 && !src_pause && $urandom_range(0, 99) >= src_idle) begin
                in_ch.valid <= 1'b1;
                in_ch.byte_value <= byte_q[0].byte_value;
                in_ch.last_byte <= byte_q[0].last_byte;
                void'(byte_q.pop_front());
            end else in_ch.valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else out_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
    end

    // monitor
    always @(posedge i_clk) begin
        t_pixel_res e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer status=%0d", out_ch.status);
                n_fail++;
            end else begin
                e = expected_q.pop_front();
                if (out_ch.pixel_fraction !== e.frac) begin
                    $error("pixel_fraction exp %0d got %0d", e.frac, out_ch.pixel_fraction);
                    n_fail++;
                end
                if (out_ch.pixel_row !== e.row) begin
                    $error("pixel_row exp %0d got %0d", e.row, out_ch.pixel_row);
                    n_fail++;
                end
                if (out_ch.pixel_col !== e.col) begin
                    $error("pixel_col exp %0d got %0d", e.col, out_ch.pixel_col);
                    n_fail++;
                end
                if (out_ch.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, out_ch.status);
                    n_fail++;
                end
                if (out_ch.image_done !== e.done) begin
                    $error("image_done exp %0d got %0d", e.done, out_ch.image_done);
                    n_fail++;
                end
            end
        end
    end

    task automatic drain();
        while (byte_q.size() > 0 || in_ch.valid || expected_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        parser_clear();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // directed: extremes, radices, each error kind
        directed_file("P5 1 1 255\n\377");
        directed_file("P5\n# c\n  +0x2 010 1 \005\001\002\003\004");
        directed_file("P5\t0XFFFF 1 255 \001");
        directed_file("P5 2 2 0xff \200\377\001");
        directed_file("P4 1 1 1 a");
        directed_file("P");
        directed_file("P5");
        directed_file("P5 0 1 1 a");
        directed_file("P5 -1 1 1 a");
        directed_file("P5 08 1 1 a");
        directed_file("P5 0x 1 1 a");
        directed_file("P5 + 1 1 a");
        directed_file("P5 65536 1 1 a");
        directed_file("P5 1 1 256 a");
        directed_file("P5 1 1 1 ");
        directed_file("P5 1 1 3 \377trailing");
        directed_file("P5 1 1 1");
        directed_file("P5 1 # 1 1 a");
        drain();
        // pressure: long receiver stall, then sender waits for empty
        for (int k = 0; k < 3; k++) build_image(4, 3, 200, 12);
        commit_file();
        hold_cycles = 400;
        drain();
        src_pause = 1;
        drain();
        src_pause = 0;
        for (int ph_i = 0; ph_i < 3; ph_i++) begin
            src_idle = (ph_i == 0) ? 36 : (ph_i == 1) ? 47 : 0;
            snk_idle = (ph_i == 0) ? 47 : (ph_i == 1) ? 36 : 0;
            for (int k = 0; k < 16; k++) random_file();
            drain();
        end
        $display("files %0d, pixel results %0d, error results %0d", n_files, n_pixels, n_errors);
        $display("covered all radices, comments, every error status and back pressure");
        if (n_fail == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
rtl/pgm_pkg.sv
rtl/pgm_if.sv
rtl/pgm_datapath.sv
rtl/pgm_ctrl.sv
rtl/pgm_binary_stream_parser.sv
sim/pgm_binary_stream_parser_tb.sv
